FILE: rtl/core/sfs_pkg.sv
// Shared types, sizes and codes for the sprite frame select core.
package sfs_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int HOLD_W     = 16;
  localparam int TOTAL_W    = 22;
  localparam int ACC_W      = (HOLD_W + CNT_W > TOTAL_W) ? (HOLD_W + CNT_W) : TOTAL_W;
  localparam int TIME_W     = 31;
  localparam int FIDX_W     = 6;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        rect_x;
    logic [15:0]        rect_y;
    logic [15:0]        rect_w;
    logic [15:0]        rect_h;
    logic [HOLD_W-1:0]  hold_ms;
    logic signed [31:0] query_ms;
  } in_beat_t;

  typedef struct packed {
    logic [15:0]       out_x;
    logic [15:0]       out_y;
    logic [15:0]       out_w;
    logic [15:0]       out_h;
    logic [FIDX_W-1:0] frame_index;
    logic              status;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } rect_t;

  typedef struct packed {
    logic               valid;
    logic               force_first;
    logic               no_match;
    logic               found;
    logic [TOTAL_W-1:0] rem;
    logic [ACC_W-1:0]   acc;
    rect_t              rect;
    logic [IDX_W-1:0]   idx;
  } token_t;

endpackage

FILE: rtl/core/sfs_mod_unit.sv
// Bit-serial restoring remainder unit: query time modulo the total duration.
module sfs_mod_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [sfs_pkg::TIME_W-1:0]  dividend,
  input  logic [sfs_pkg::TOTAL_W-1:0] divisor,
  output logic                        done,
  output logic [sfs_pkg::TOTAL_W-1:0] rem
);
  import sfs_pkg::*;

  localparam int STEP_W = $clog2(TIME_W + 1);

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [TIME_W-1:0]   sh_r, sh_nxt;
  logic [TOTAL_W-1:0]  div_r, div_nxt;
  logic [TOTAL_W-1:0]  rem_r, rem_nxt;
  logic [TOTAL_W:0]    trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, sh_r[TIME_W-1]};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = STEP_W'(TIME_W);
      sh_nxt  = dividend;
      div_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      sh_nxt = {sh_r[TIME_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = TOTAL_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = TOTAL_W'(trial);
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/core/sfs_cell.sv
// One frame cell: holds a frame and advances the query token by one stage.
module sfs_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sfs_pkg::token_t            tok_in,
  input  logic                       wr_en,
  input  sfs_pkg::rect_t             wr_rect,
  input  logic [sfs_pkg::HOLD_W-1:0] wr_hold,
  input  logic                       active,
  input  logic [sfs_pkg::IDX_W-1:0]  cell_idx,
  output sfs_pkg::token_t            tok_out
);
  import sfs_pkg::*;

  rect_t             rect_r;
  logic [HOLD_W-1:0] hold_r;
  token_t            tok_r, tok_nxt;
  logic [ACC_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rect_r <= wr_rect;
      hold_r <= wr_hold;
    end
  end

  always_comb begin
    sum     = tok_in.acc + ACC_W'(hold_r);
    tok_nxt = tok_in;
    if (tok_in.valid && active && !tok_in.found) begin
      tok_nxt.acc  = sum;
      tok_nxt.rect = rect_r;
      tok_nxt.idx  = cell_idx;
      if (tok_in.force_first || (!tok_in.no_match && (ACC_W'(tok_in.rem) < sum))) begin
        tok_nxt.found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: rtl/core/sprite_frame_select_core.sv
// Top level of the sprite frame select core: frame cells, remainder unit, control.
//
//   channel  ports                      direction  handshake
//   input    start, busy, in_data       in         beat taken when start && !busy
//   result   out_valid, out_data        out        one-cycle strobe, no back-pressure
//
// Clear and append beats are taken in idle and keep busy low.
// A query holds busy while the bit-serial remainder unit runs its 31 steps,
// the remainder is handed to the first cell and the token then crosses
// all MAX_FRAMES cells; the result strobe follows.
// Negative time or a zero total skips the remainder unit and holds busy only
// for the cell walk. An empty table answers in the cycle after the beat.
// Reset is synchronous and empties the table; the receiver cannot stall.
module sprite_frame_select_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sfs_pkg::in_beat_t  in_data,
  output logic               out_valid,
  output sfs_pkg::out_beat_t out_data
);
  import sfs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_WALK = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r, out_data_nxt;

  logic               accept;
  logic               append_we;
  logic               div_go;
  logic               div_done;
  logic [TOTAL_W-1:0] div_rem;
  token_t             head;
  token_t             tok_chain [MAX_FRAMES+1];
  logic [MAX_FRAMES:0] tok_valid;
  rect_t              wr_rect;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign wr_rect.x = in_data.rect_x;
  assign wr_rect.y = in_data.rect_y;
  assign wr_rect.w = in_data.rect_w;
  assign wr_rect.h = in_data.rect_h;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    append_we     = 1'b0;
    div_go        = 1'b0;
    head          = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            OP_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
            end
            OP_APPEND: begin
              if (count_r < CNT_W'(MAX_FRAMES)) begin
                append_we = 1'b1;
                count_nxt = count_r + 1'b1;
                total_nxt = total_r + TOTAL_W'(in_data.hold_ms);
              end
            end
            OP_QUERY: begin
              if (count_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt        = '0;
                out_data_nxt.status = 1'b1;
              end else if (in_data.query_ms[31] || (total_r == '0)) begin
                head.valid       = 1'b1;
                head.force_first = in_data.query_ms[31];
                head.no_match    = !in_data.query_ms[31];
                state_nxt        = ST_WALK;
              end else begin
                div_go    = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          head.valid = 1'b1;
          head.rem   = div_rem;
          state_nxt  = ST_WALK;
        end
      end
      ST_WALK: begin
        if (tok_chain[MAX_FRAMES].valid) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_x       = tok_chain[MAX_FRAMES].rect.x;
          out_data_nxt.out_y       = tok_chain[MAX_FRAMES].rect.y;
          out_data_nxt.out_w       = tok_chain[MAX_FRAMES].rect.w;
          out_data_nxt.out_h       = tok_chain[MAX_FRAMES].rect.h;
          out_data_nxt.frame_index = FIDX_W'(tok_chain[MAX_FRAMES].idx);
          out_data_nxt.status      = 1'b0;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  sfs_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (in_data.query_ms[TIME_W-1:0]),
    .divisor  (total_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign tok_chain[0] = head;
  assign tok_valid[0] = head.valid;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    sfs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok_chain[i]),
      .wr_en    (append_we && (count_r == CNT_W'(i))),
      .wr_rect  (wr_rect),
      .wr_hold  (in_data.hold_ms),
      .active   (CNT_W'(i) < count_r),
      .cell_idx (IDX_W'(i)),
      .tok_out  (tok_chain[i+1])
    );
    assign tok_valid[i+1] = tok_chain[i+1].valid;
  end

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_valid) <= 1)
    else $error("More than one query token in the cell chain.");

  a_token_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tok_chain[MAX_FRAMES].valid |-> (state_r == ST_WALK))
    else $error("Token left the chain outside the walk state.");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("Remainder finished outside the divide state.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_FRAMES))
    else $error("Frame count exceeds the table size.");

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_WALK) || ($past(accept) && !out_data.status == 1'b0))
    else $error("Result beat without a finished query.");

endmodule
